### src/ozc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ozc_pkg
// Types, codes and fixed constants shared by the obstacle zone classifier.
// ----------------------------------------------------------------------------
package ozc_pkg;

    // Slope of the wedge lines, tan(pi/18) at scale 2^16
    localparam int KB_Q16 = 11556;

    // Zone counter slots
    localparam int NUM_ZONES = 13;
    typedef enum logic [3:0] {
        Z_DANGER,
        Z_ROUTE_S,
        Z_ROUTE_M,
        Z_PRED_S,
        Z_PRED_M,
        Z_BUFFER,
        Z_FRONT,
        Z_QLEFT,
        Z_QRIGHT,
        Z_REVOLUTE,
        Z_ASSIST,
        Z_BACK_L,
        Z_BACK_R
    } t_zone;

    // Input codes
    typedef enum logic [1:0] {
        TAG_OTHER  = 2'd0,
        TAG_SENSOR = 2'd1,
        TAG_MAP    = 2'd2
    } t_tag;

    typedef enum logic [1:0] {
        MOTION_STOP = 2'd0,
        MOTION_FWD  = 2'd1,
        MOTION_BWD  = 2'd2
    } t_motion;

    typedef enum logic [1:0] {
        TURN_BALANCED = 2'd0,
        TURN_LEFT     = 2'd1,
        TURN_RIGHT    = 2'd2
    } t_turn;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_HALF_LENGTH = 3'd0,
        CFG_HALF_WIDTH  = 3'd1,
        CFG_ROUTE       = 3'd2,
        CFG_PREDICT     = 3'd3,
        CFG_BUFFER      = 3'd4,
        CFG_FORE_SAFE   = 3'd5,
        CFG_ASSIST      = 3'd6,
        CFG_REVOLUTE    = 3'd7
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [14:0] HALF_LENGTH_RST = 15'd350;
    localparam logic [14:0] HALF_WIDTH_RST  = 15'd250;
    localparam logic [29:0] ROUTE_SQ_RST    = 30'(5000 * 5000);
    localparam logic [29:0] PREDICT_SQ_RST  = 30'(10000 * 10000);
    localparam logic [29:0] BUFFER_SQ_RST   = 30'(2000 * 2000);
    localparam logic [29:0] FRONT_SQ_RST    = 30'(1000 * 1000);
    localparam logic [29:0] ASSIST_SQ_RST   = 30'(1000 * 1000);
    localparam logic [29:0] REVOLUTE_SQ_RST = 30'(500 * 500);

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Channel payloads
    typedef struct packed {
        logic signed [15:0] point_x_mm;
        logic signed [15:0] point_y_mm;
        logic [1:0]         source_tag;
        logic [1:0]         motion;
        logic [14:0]        danger_radius_mm;
        logic               last_point;
    } t_point;

    typedef struct packed {
        logic       danger_flag;
        logic       assist_flag;
        logic       route_sensor_flag;
        logic       route_chart_flag;
        logic       predict_sensor_flag;
        logic       predict_chart_flag;
        logic       buffer_flag;
        logic       fore_safe_flag;
        logic       spin_flag;
        logic       rear_left_flag;
        logic       rear_right_flag;
        logic [1:0] turn_hint;
    } t_result;

    typedef struct packed {
        logic [2:0]  index;
        logic [14:0] data;
    } t_cfg_write;

    // Live configuration, radii held squared
    typedef struct packed {
        logic [14:0] half_length;
        logic [14:0] half_width;
        logic [29:0] route_sq;
        logic [29:0] predict_sq;
        logic [29:0] buffer_sq;
        logic [29:0] front_sq;
        logic [29:0] assist_sq;
        logic [29:0] revolute_sq;
    } t_cfg;

    // Classified point travelling from front to back
    typedef struct packed {
        logic [NUM_ZONES-1:0] hits;
        logic                 last;
    } t_hit_item;

endpackage

### src/ozc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ozc_stream_if
// Valid/ready channel carrying one request payload of a chosen type.
// ----------------------------------------------------------------------------
interface ozc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/ozc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ozc_cfg_regs
// Configuration register file; radii are squared once on write.
// ----------------------------------------------------------------------------
module ozc_cfg_regs (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ozc_stream_if.sink   i_cfg,
    output ozc_pkg::t_cfg o_cfg
);

    ozc_pkg::t_cfg r_cfg;
    logic [29:0]   w_sq;
    logic          w_wr;

    // Always take a write request
    assign i_cfg.ready = 1'b1;
    assign w_wr        = i_cfg.valid;

    // Square the write data with one shared multiplier
    assign w_sq = 30'(i_cfg.payload.data) * 30'(i_cfg.payload.data);

    // Hold the registers, update the addressed one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_length <= ozc_pkg::HALF_LENGTH_RST;
            r_cfg.half_width  <= ozc_pkg::HALF_WIDTH_RST;
            r_cfg.route_sq    <= ozc_pkg::ROUTE_SQ_RST;
            r_cfg.predict_sq  <= ozc_pkg::PREDICT_SQ_RST;
            r_cfg.buffer_sq   <= ozc_pkg::BUFFER_SQ_RST;
            r_cfg.front_sq    <= ozc_pkg::FRONT_SQ_RST;
            r_cfg.assist_sq   <= ozc_pkg::ASSIST_SQ_RST;
            r_cfg.revolute_sq <= ozc_pkg::REVOLUTE_SQ_RST;
        end else if (w_wr) begin
            case (i_cfg.payload.index)
                ozc_pkg::CFG_HALF_LENGTH: r_cfg.half_length <= i_cfg.payload.data;
                ozc_pkg::CFG_HALF_WIDTH:  r_cfg.half_width  <= i_cfg.payload.data;
                ozc_pkg::CFG_ROUTE:       r_cfg.route_sq    <= w_sq;
                ozc_pkg::CFG_PREDICT:     r_cfg.predict_sq  <= w_sq;
                ozc_pkg::CFG_BUFFER:      r_cfg.buffer_sq   <= w_sq;
                ozc_pkg::CFG_FORE_SAFE:   r_cfg.front_sq    <= w_sq;
                ozc_pkg::CFG_ASSIST:      r_cfg.assist_sq   <= w_sq;
                ozc_pkg::CFG_REVOLUTE:    r_cfg.revolute_sq <= w_sq;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/ozc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ozc_front
// Two-stage classifier: products first, then zone tests into a hit vector.
// ----------------------------------------------------------------------------
module ozc_front #(
    parameter int BACK_SAFE_RADIUS_MM = 1000,
    parameter int WEDGE_OFFSET_MM     = 300
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ozc_stream_if.sink        i_point,
    input  ozc_pkg::t_cfg     i_cfg,
    input  logic              i_full,
    output logic              o_push,
    output ozc_pkg::t_hit_item o_push_data
);

    localparam logic [29:0] BACK_SQ =
        30'(BACK_SAFE_RADIUS_MM * BACK_SAFE_RADIUS_MM);
    localparam logic signed [34:0] OFF = 35'(WEDGE_OFFSET_MM) <<< 16;

    // Stage 1 registers
    logic                     r_s1_v;
    logic signed [15:0]       r_x;
    logic signed [15:0]       r_y;
    logic [30:0]              r_x2;
    logic [30:0]              r_y2;
    logic [29:0]              r_rd2;
    logic signed [29:0]       r_kx;
    logic [1:0]               r_tag;
    logic [1:0]               r_motion;
    logic                     r_last;

    // Stage 2 registers
    logic                     r_s2_v;
    ozc_pkg::t_hit_item       r_s2;

    logic                     w_s1_en;
    logic                     w_s2_en;
    logic signed [31:0]       w_x2;
    logic signed [31:0]       w_y2;
    logic [29:0]              w_rd2;
    logic signed [29:0]       w_kx;
    logic [31:0]              w_d2;
    logic signed [34:0]       w_kx_l;
    logic signed [34:0]       w_yq;
    logic signed [34:0]       w_fa;
    logic signed [34:0]       w_fs;
    logic signed [34:0]       w_ba;
    logic signed [34:0]       w_bs;
    logic signed [34:0]       w_sa;
    logic signed [34:0]       w_ss;
    logic signed [16:0]       w_xe;
    logic signed [16:0]       w_ye;
    logic signed [16:0]       w_hl;
    logic signed [16:0]       w_hw;
    ozc_pkg::t_hit_item       n_s2;

    // Advance when the next place is free
    assign w_s2_en       = !r_s2_v || !i_full;
    assign w_s1_en       = !r_s1_v || w_s2_en;
    assign i_point.ready = w_s1_en;
    assign o_push        = r_s2_v && !i_full;
    assign o_push_data   = r_s2;

    // Stage 1 products
    assign w_x2  = i_point.payload.point_x_mm * i_point.payload.point_x_mm;
    assign w_y2  = i_point.payload.point_y_mm * i_point.payload.point_y_mm;
    assign w_rd2 = 30'(i_point.payload.danger_radius_mm) *
                   30'(i_point.payload.danger_radius_mm);
    assign w_kx  = 30'(ozc_pkg::KB_Q16) * 30'(i_point.payload.point_x_mm);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_s1_en) begin
                r_s1_v <= i_point.valid;
            end
            if (w_s2_en) begin
                r_s2_v <= r_s1_v;
            end
        end
    end

    // Load stage payloads
    always_ff @(posedge i_clk) begin
        if (w_s1_en && i_point.valid) begin
            r_x      <= i_point.payload.point_x_mm;
            r_y      <= i_point.payload.point_y_mm;
            r_x2     <= w_x2[30:0];
            r_y2     <= w_y2[30:0];
            r_rd2    <= w_rd2;
            r_kx     <= w_kx;
            r_tag    <= i_point.payload.source_tag;
            r_motion <= i_point.payload.motion;
            r_last   <= i_point.payload.last_point;
        end
        if (w_s2_en && r_s1_v) begin
            r_s2 <= n_s2;
        end
    end

    // Stage 2 zone tests
    always_comb begin
        logic fwd_wedge;
        logic back_wedge;
        logic box;
        logic in_circle;
        logic route_ring;
        logic pred_ring;
        logic in_buffer;

        w_d2   = {1'b0, r_x2} + {1'b0, r_y2};
        w_kx_l = 35'(r_kx);
        w_yq   = 35'(r_y) <<< 16;
        w_fa   = w_kx_l + w_yq + OFF;
        w_fs   = w_kx_l - w_yq + OFF;
        w_ba   = w_kx_l + w_yq - OFF;
        w_bs   = w_kx_l - w_yq - OFF;
        w_sa   = w_kx_l + w_yq;
        w_ss   = w_kx_l - w_yq;
        w_xe   = 17'(r_x);
        w_ye   = 17'(r_y);
        w_hl   = $signed({2'b00, i_cfg.half_length});
        w_hw   = $signed({2'b00, i_cfg.half_width});

        box        = (w_xe >= -w_hl) && (w_xe <= w_hl) &&
                     (w_ye >= -w_hw) && (w_ye <= w_hw);
        fwd_wedge  = (w_fa >= 0) && (w_fs >= 0) && (r_x >= 0);
        back_wedge = (w_ba <= 0) && (w_bs <= 0) && (r_x <= 0);
        in_circle  = w_d2 <= {2'b00, r_rd2};
        route_ring = (w_d2 <= {2'b00, i_cfg.route_sq}) && (w_d2 > {2'b00, r_rd2});
        pred_ring  = (w_d2 <= {2'b00, i_cfg.predict_sq}) &&
                     (w_d2 > {2'b00, i_cfg.route_sq});
        in_buffer  = fwd_wedge && (w_d2 <= {2'b00, i_cfg.buffer_sq});

        n_s2.hits = '0;
        n_s2.last = r_last;

        // Danger: circle and wedge by motion, box always
        case (r_motion)
            ozc_pkg::MOTION_FWD: n_s2.hits[ozc_pkg::Z_DANGER] = (in_circle && fwd_wedge) || box;
            ozc_pkg::MOTION_BWD: n_s2.hits[ozc_pkg::Z_DANGER] = (in_circle && back_wedge) || box;
            default:             n_s2.hits[ozc_pkg::Z_DANGER] = box;
        endcase

        // Forward wedge rings, buffer and front safe
        n_s2.hits[ozc_pkg::Z_ROUTE_S] = fwd_wedge && route_ring && (r_tag == ozc_pkg::TAG_SENSOR);
        n_s2.hits[ozc_pkg::Z_ROUTE_M] = fwd_wedge && route_ring && (r_tag == ozc_pkg::TAG_MAP);
        n_s2.hits[ozc_pkg::Z_PRED_S]  = fwd_wedge && pred_ring && (r_tag == ozc_pkg::TAG_SENSOR);
        n_s2.hits[ozc_pkg::Z_PRED_M]  = fwd_wedge && pred_ring && (r_tag == ozc_pkg::TAG_MAP);
        n_s2.hits[ozc_pkg::Z_BUFFER]  = in_buffer;
        n_s2.hits[ozc_pkg::Z_QLEFT]   = in_buffer && (r_x > 0) && (r_y > 0);
        n_s2.hits[ozc_pkg::Z_QRIGHT]  = in_buffer && (r_x > 0) && (r_y < 0);
        n_s2.hits[ozc_pkg::Z_FRONT]   = fwd_wedge && (w_d2 <= {2'b00, i_cfg.front_sq});

        // Revolute circle and side assist wedges
        n_s2.hits[ozc_pkg::Z_REVOLUTE] = w_d2 <= {2'b00, i_cfg.revolute_sq};
        n_s2.hits[ozc_pkg::Z_ASSIST]   = (w_d2 <= {2'b00, i_cfg.assist_sq}) &&
                                         (((w_ba >= 0) && (w_fs <= 0)) ||
                                          ((w_fa <= 0) && (w_bs >= 0)));

        // Rear safe halves
        n_s2.hits[ozc_pkg::Z_BACK_L] = (w_d2 <= {2'b00, BACK_SQ}) && (r_x <= 0) && (w_sa >= 0);
        n_s2.hits[ozc_pkg::Z_BACK_R] = (w_d2 <= {2'b00, BACK_SQ}) && (r_x <= 0) && (w_ss >= 0);
    end

endmodule

### src/ozc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ozc_queue
// Short queue of classified points between front and back.
// ----------------------------------------------------------------------------
module ozc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ozc_pkg::t_hit_item i_push_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_head_v,
    output ozc_pkg::t_hit_item o_head
);

    localparam int DEPTH = ozc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ozc_pkg::t_hit_item r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_pop;

    assign o_full   = r_count == CNT_W'(DEPTH);
    assign o_head_v = r_count != '0;
    assign o_head   = r_mem[r_rptr];
    assign w_pop    = i_pop && o_head_v;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store a request
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !w_pop))
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

### src/ozc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ozc_back
// Saturating zone counters; emits flags and turn hint on the last point.
// ----------------------------------------------------------------------------
module ozc_back #(
    parameter int MAX_POINTS = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_v,
    input  ozc_pkg::t_hit_item i_head,
    output logic               o_pop,
    ozc_stream_if.source       o_result
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int NZ    = ozc_pkg::NUM_ZONES;

    logic [CNT_W-1:0]  r_cnt [NZ];
    logic [CNT_W-1:0]  n_cnt [NZ];
    logic              r_ov;
    ozc_pkg::t_result  r_res;
    ozc_pkg::t_result  w_res;
    logic              w_pop;
    logic              w_close;

    // Take a request unless it closes a cloud while the result is held
    assign w_pop   = i_head_v && (!i_head.last || !r_ov || o_result.ready);
    assign w_close = w_pop && i_head.last;
    assign o_pop   = w_pop;

    // Next counts, including the popped point
    always_comb begin
        for (int z = 0; z < NZ; z++) begin
            n_cnt[z] = r_cnt[z];
            if (w_pop && i_head.hits[z] &&
                ({1'b0, r_cnt[z]} < (CNT_W + 1)'(MAX_POINTS))) begin
                n_cnt[z] = r_cnt[z] + 1'b1;
            end
        end
    end

    // Flags from the final counts
    always_comb begin
        w_res.danger_flag         = n_cnt[ozc_pkg::Z_DANGER] != '0;
        w_res.assist_flag         = {2'b00, n_cnt[ozc_pkg::Z_ASSIST]} > (CNT_W + 2)'(2);
        w_res.route_sensor_flag   = n_cnt[ozc_pkg::Z_ROUTE_S] != '0;
        w_res.route_chart_flag    = n_cnt[ozc_pkg::Z_ROUTE_M] != '0;
        w_res.predict_sensor_flag = n_cnt[ozc_pkg::Z_PRED_S] != '0;
        w_res.predict_chart_flag  = n_cnt[ozc_pkg::Z_PRED_M] != '0;
        w_res.buffer_flag         = {2'b00, n_cnt[ozc_pkg::Z_BUFFER]} > (CNT_W + 2)'(2);
        w_res.fore_safe_flag      = n_cnt[ozc_pkg::Z_FRONT] != '0;
        w_res.spin_flag           = {2'b00, n_cnt[ozc_pkg::Z_REVOLUTE]} > (CNT_W + 2)'(2);
        w_res.rear_left_flag      = n_cnt[ozc_pkg::Z_BACK_L] != '0;
        w_res.rear_right_flag     = n_cnt[ozc_pkg::Z_BACK_R] != '0;
        if (n_cnt[ozc_pkg::Z_QLEFT] > n_cnt[ozc_pkg::Z_QRIGHT]) begin
            w_res.turn_hint = ozc_pkg::TURN_LEFT;
        end else if (n_cnt[ozc_pkg::Z_QLEFT] < n_cnt[ozc_pkg::Z_QRIGHT]) begin
            w_res.turn_hint = ozc_pkg::TURN_RIGHT;
        end else begin
            w_res.turn_hint = ozc_pkg::TURN_BALANCED;
        end
    end

    // Update counters, drop them after a cloud closes; hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int z = 0; z < NZ; z++) begin
                r_cnt[z] <= '0;
            end
            r_ov <= 1'b0;
        end else begin
            for (int z = 0; z < NZ; z++) begin
                r_cnt[z] <= w_close ? '0 : n_cnt[z];
            end
            if (w_close) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_res <= w_res;
        end
    end

    assign o_result.valid   = r_ov;
    assign o_result.payload = r_res;

    a_close_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> r_ov)
        else $error("closed cloud without a result");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> (r_cnt[ozc_pkg::Z_DANGER] == '0) && (r_cnt[ozc_pkg::Z_BUFFER] == '0) &&
                    (r_cnt[ozc_pkg::Z_QLEFT] == '0))
        else $error("counters not cleared after last point");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_result.ready) |-> !w_close)
        else $error("pending result overwritten");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cnt[ozc_pkg::Z_ASSIST]} <= (CNT_W + 1)'(MAX_POINTS))
        else $error("counter beyond saturation");

endmodule

### src/obstacle_zone_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obstacle_zone_classifier
// Sorts obstacle points into safety zones and reports flags per cloud.
// ----------------------------------------------------------------------------
// Throughput: one point per cycle while the queue is not full, set by the
//   two-stage classifier pipeline.
// Result path: the last point of a cloud passes both classifier stages, the
//   queue write and the result register before the result turns valid.
// Reset clears the counters, the pipeline and the queue at once, and returns
//   every configuration register to its reset value.
// ----------------------------------------------------------------------------
module obstacle_zone_classifier #(
    parameter int MAX_POINTS          = 65536,
    parameter int BACK_SAFE_RADIUS_MM = 1000,
    parameter int WEDGE_OFFSET_MM     = 300
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ozc_stream_if.sink   i_point,
    ozc_stream_if.sink   i_cfg,
    ozc_stream_if.source o_result
);

    ozc_pkg::t_cfg      w_cfg;
    logic               w_push;
    ozc_pkg::t_hit_item w_push_data;
    logic               w_full;
    logic               w_pop;
    logic               w_head_v;
    ozc_pkg::t_hit_item w_head;

    // Configuration registers
    ozc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Classifier front
    ozc_front #(
        .BACK_SAFE_RADIUS_MM (BACK_SAFE_RADIUS_MM),
        .WEDGE_OFFSET_MM     (WEDGE_OFFSET_MM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_point     (i_point),
        .i_cfg       (w_cfg),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Decoupling queue
    ozc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_head_v    (w_head_v),
        .o_head      (w_head)
    );

    // Counters and result
    ozc_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head_v (w_head_v),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

endmodule
